### src/mtcr_pkg.sv
// ----------------------------------------------------------------------------
// mtcr_pkg
// Shared types and constants for the monochrome text cell row renderer.
// ----------------------------------------------------------------------------
package mtcr_pkg;

    localparam int FONT_DEPTH    = 4096;
    localparam int FONT_AW       = 12;
    localparam int GLYPH_ROWS    = 16;
    localparam int CELL_PIXELS   = 9;
    localparam int COLOR_W       = 24;

    localparam logic [0:0] CMD_LOAD   = 1'b0;
    localparam logic [0:0] CMD_RENDER = 1'b1;

    localparam logic [0:0] REG_REGULAR_COLOR = 1'b0;
    localparam logic [0:0] REG_INTENSE_COLOR = 1'b1;

    localparam logic [23:0] REGULAR_COLOR_RESET = 24'hCC9900;
    localparam logic [23:0] INTENSE_COLOR_RESET = 24'hFFCF00;

    localparam logic [7:0] ATTR_CLASS_MASK = 8'h77;
    localparam logic [7:0] ATTR_BLANK      = 8'h00;
    localparam logic [7:0] ATTR_INVERTED   = 8'h70;
    localparam logic [2:0] ATTR_UNDERLINE  = 3'b001;
    localparam logic [3:0] UNDERLINE_ROW   = 4'd14;

    localparam logic [8:0] ALL_PIXELS = 9'h1FF;

    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] attr;
        logic [3:0] row;
        logic       blink_on;
    } cell_t;

endpackage

### src/mtcr_attr_decode.sv
// ----------------------------------------------------------------------------
// mtcr_attr_decode
// Resolves one cell row: attribute classes, underline, blink and colour.
// ----------------------------------------------------------------------------
module mtcr_attr_decode (
    input  mtcr_pkg::cell_t cur_cell,
    input  logic [23:0]     regular_color,
    input  logic [23:0]     intense_color,
    output logic [8:0]      lit_mask,
    output logic [23:0]     pixel_color
);
    import mtcr_pkg::*;

    logic [7:0] glyph_row;
    logic [8:0] glyph_mask;
    logic       visible;
    logic       is_blank;
    logic       is_inverted;
    logic       underline;

    always_comb begin
        glyph_row   = (cur_cell.row < 4'(GLYPH_ROWS - 1) || cur_cell.row == 4'(GLYPH_ROWS - 1))
                      ? cur_cell.glyph : 8'h00;
        glyph_mask  = {glyph_row, 1'b0};
        visible     = !cur_cell.attr[7] || cur_cell.blink_on;
        is_blank    = (cur_cell.attr & ATTR_CLASS_MASK) == ATTR_BLANK;
        is_inverted = (cur_cell.attr & ATTR_CLASS_MASK) == ATTR_INVERTED;
        underline   = cur_cell.attr[2:0] == ATTR_UNDERLINE && cur_cell.row == UNDERLINE_ROW;

        pixel_color = cur_cell.attr[3] ? intense_color : regular_color;
        lit_mask    = '0;
        priority if (is_blank) begin
            pixel_color = '0;
        end else if (is_inverted) begin
            lit_mask = visible ? (ALL_PIXELS & ~glyph_mask) : ALL_PIXELS;
        end else if (visible) begin
            lit_mask = underline ? ALL_PIXELS : glyph_mask;
        end
    end

endmodule

### src/mda_text_cell_row_render.sv
// ----------------------------------------------------------------------------
// mda_text_cell_row_render
// Monochrome text-mode cell row generator with a 256 x 16 font store.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while s_tready is high. A load (tuser = 0) writes
// one font byte in the cycle it is accepted and returns nothing; a render (tuser = 1)
// reads the font store's registered read port and returns its cell row through an
// output register, so a waiting result never blocks the next input unless both
// pipeline registers are full.
module mda_text_cell_row_render (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input: font_address[11:0], font_byte[19:12], char_code[27:20],
    // attr_byte[35:28], scan_row[39:36], blink_on[40], zero[47:41]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,   // cmd[0]
    // result: lit_mask[8:0], pixel_color[32:9], zero[39:33]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);
    import mtcr_pkg::*;

    logic [7:0]  font_mem [FONT_DEPTH];

    logic [23:0] regular_color_reg;
    logic [23:0] intense_color_reg;

    logic        p1_valid_reg;
    logic [7:0]  glyph_reg;
    logic [7:0]  attr_reg;
    logic [3:0]  row_reg;
    logic        blink_reg;

    logic        m_valid_reg;
    logic [8:0]  mask_reg;
    logic [23:0] color_reg;

    logic        s_accept;
    logic        out_ready;
    logic        p1_advance;
    logic        cfg_write;
    cell_t       cur_cell;
    logic [8:0]  mask_next;
    logic [23:0] color_next;

    logic [11:0] in_addr;
    logic [7:0]  in_byte;
    logic [7:0]  in_char;

    assign in_addr = s_tdata[11:0];
    assign in_byte = s_tdata[19:12];
    assign in_char = s_tdata[27:20];

    assign out_ready  = !m_valid_reg || m_tready;
    assign p1_advance = p1_valid_reg && out_ready;
    assign s_tready   = !p1_valid_reg || out_ready;
    assign s_accept   = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {8'h00, (paddr[2] == REG_INTENSE_COLOR) ? intense_color_reg
                                                              : regular_color_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regular_color_reg <= REGULAR_COLOR_RESET;
            intense_color_reg <= INTENSE_COLOR_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_REGULAR_COLOR) begin
                regular_color_reg <= pwdata[23:0];
            end else begin
                intense_color_reg <= pwdata[23:0];
            end
        end
    end

    // font store
    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == CMD_LOAD) begin
            font_mem[in_addr] <= in_byte;
        end
        if (s_accept && s_tuser == CMD_RENDER) begin
            glyph_reg <= font_mem[{in_char, s_tdata[39:36]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_accept && s_tuser == CMD_RENDER;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == CMD_RENDER) begin
            attr_reg  <= s_tdata[35:28];
            row_reg   <= s_tdata[39:36];
            blink_reg <= s_tdata[40];
        end
    end

    assign cur_cell = '{glyph: glyph_reg, attr: attr_reg, row: row_reg, blink_on: blink_reg};

    mtcr_attr_decode u_decode (
        .cur_cell      (cur_cell),
        .regular_color (regular_color_reg),
        .intense_color (intense_color_reg),
        .lit_mask      (mask_next),
        .pixel_color   (color_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance) begin
            mask_reg  <= mask_next;
            color_reg <= color_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'h00, color_reg, mask_reg};

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the monochrome text cell row renderer.
// ----------------------------------------------------------------------------
// Font loads and cell row renders go in through the input stream with random
// gaps, and results are taken with random stalls. A cycle-free model of the
// attribute decoder, with its own copy of the font store and the colors,
// works out each cell row when a render is accepted. Every result is checked
// against the oldest pending row. Renders only read font entries already
// loaded. The two color registers are read back after reset and after each
// write, and are changed between phases once the block has gone idle.
// ----------------------------------------------------------------------------
module tb;

    import mtcr_pkg::*;

    typedef struct packed {
        logic [0:0] cmd;
        logic [11:0] addr;
        logic [7:0]  fbyte;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [3:0]  row;
        logic        blink_on;
    } cell_item_t;

    typedef struct packed {
        logic [8:0]  mask;
        logic [23:0] color;
    } cell_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // font_address, font_byte, char_code, attr_byte, scan_row, blink_on
    logic        s_tuser = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // lit_mask, pixel_color

    cell_item_t  pending_cells[$];
    cell_row_t   rows_due[$];
    cell_item_t  on_wire;
    logic [7:0]  font_shadow [FONT_DEPTH];
    logic [23:0] regular_shadow = REGULAR_COLOR_RESET;
    logic [23:0] intense_shadow = INTENSE_COLOR_RESET;
    bit          loaded [FONT_DEPTH];
    int          loaded_addrs[$];
    bit          no_idle = 1'b0;
    int          send_gap = 0;
    int          sink_stall = 0;
    int          n_loads = 0;
    int          n_renders = 0;
    int          n_checked = 0;
    int          n_settings = 1;
    int          fail_count = 0;

    mda_text_cell_row_render DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string msg);
        if (fail_count < 25)
            $display("tb: mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic cell_row_t render_cell_row(input cell_item_t c);
        logic [7:0] glyph;
        logic       visible;
        cell_row_t  r;
        glyph   = (c.row < GLYPH_ROWS) ? font_shadow[{c.ch, c.row}] : 8'h00;
        r.color = c.attr[3] ? intense_shadow : regular_shadow;
        visible = !c.attr[7] || c.blink_on;
        if ((c.attr & ATTR_CLASS_MASK) == ATTR_BLANK) begin
            r.mask  = '0;
            r.color = '0;
        end else if ((c.attr & ATTR_CLASS_MASK) == ATTR_INVERTED) begin
            r.mask = ALL_PIXELS;
            if (visible)
                r.mask = r.mask & ~{glyph, 1'b0};
        end else begin
            r.mask = '0;
            if (visible) begin
                r.mask = {glyph, 1'b0};
                if (c.attr[2:0] == ATTR_UNDERLINE && c.row == UNDERLINE_ROW)
                    r.mask = ALL_PIXELS;
            end
        end
        return r;
    endfunction

    // input side
    always @(posedge aclk) begin : driver
        cell_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (on_wire.cmd == CMD_LOAD) begin
                    font_shadow[on_wire.addr] = on_wire.fbyte;
                    n_loads++;
                end else begin
                    rows_due.push_back(render_cell_row(on_wire));
                    n_renders++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cells.size() > 0) begin
                    nxt = pending_cells.pop_front();
                    on_wire  <= nxt;
                    s_tdata  <= {7'b0, nxt.blink_on, nxt.row, nxt.attr, nxt.ch,
                                 nxt.fbyte, nxt.addr};
                    s_tuser  <= nxt.cmd;
                    s_tvalid <= 1'b1;
                    send_gap <= idle_draw();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin : monitor
        cell_row_t want;
        int        n;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            if (rows_due.size() == 0) begin
                report($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = rows_due.pop_front();
                if (m_tdata[8:0] !== want.mask)
                    report($sformatf("lit_mask %h, want %h", m_tdata[8:0], want.mask));
                if (m_tdata[32:9] !== want.color)
                    report($sformatf("pixel_color %h, want %h", m_tdata[32:9], want.color));
                n_checked++;
            end
            n = idle_draw();
            sink_stall <= n;
            m_tready   <= (n == 0);
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready   <= (sink_stall == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic color_access(input logic wr, input logic [0:0] idx, input logic [23:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'h00, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!wr && prdata !== {8'h00, val})
            report($sformatf("register %0d reads %h, want %h", idx, prdata, val));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_colors(input logic [23:0] regular, input logic [23:0] intense);
        color_access(1'b1, REG_REGULAR_COLOR, regular);
        color_access(1'b1, REG_INTENSE_COLOR, intense);
        regular_shadow = regular;
        intense_shadow = intense;
        color_access(1'b0, REG_REGULAR_COLOR, regular);
        color_access(1'b0, REG_INTENSE_COLOR, intense);
        n_settings++;
    endtask

    task automatic queue_load(input logic [11:0] addr, input logic [7:0] fbyte);
        cell_item_t c;
        c.cmd      = CMD_LOAD;
        c.addr     = addr;
        c.fbyte    = fbyte;
        c.ch       = 8'($urandom);
        c.attr     = 8'($urandom);
        c.row      = 4'($urandom);
        c.blink_on = 1'($urandom);
        pending_cells.push_back(c);
        if (!loaded[addr]) begin
            loaded[addr] = 1'b1;
            loaded_addrs.push_back(addr);
        end
    endtask

    task automatic queue_render(input logic [7:0] ch, input logic [7:0] attr,
                                input logic [3:0] row, input logic blink_on);
        cell_item_t c;
        c.cmd      = CMD_RENDER;
        c.addr     = 12'($urandom);
        c.fbyte    = 8'($urandom);
        c.ch       = ch;
        c.attr     = attr;
        c.row      = row;
        c.blink_on = blink_on;
        pending_cells.push_back(c);
    endtask

    function automatic logic [7:0] pick_attr();
        logic [7:0] a;
        a = 8'($urandom);
        case ($urandom_range(0, 5))
            0: a = a & 8'h88;
            1: a = (a & 8'h88) | 8'h70;
            2: a = {a[7:3], ATTR_UNDERLINE};
            default: ;
        endcase
        return a;
    endfunction

    task automatic wait_idle();
        while (pending_cells.size() > 0 || s_tvalid || rows_due.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [11:0] a;
        int          pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        color_access(1'b0, REG_REGULAR_COLOR, REGULAR_COLOR_RESET);
        color_access(1'b0, REG_INTENSE_COLOR, INTENSE_COLOR_RESET);

        // two glyphs filled on every row, one empty row and two full rows among them
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            queue_load({8'h00, 4'(r)}, (r == 0) ? 8'h00 : (r == 15) ? 8'hFF : 8'($urandom));
            queue_load({8'hFF, 4'(r)}, (r == 15) ? 8'hFF : 8'($urandom));
        end
        queue_render(8'h00, 8'h07, 4'd0,  1'b1);
        queue_render(8'h00, 8'h07, 4'd15, 1'b1);
        queue_render(8'hFF, 8'h0F, 4'd15, 1'b0);
        queue_render(8'h00, 8'h00, 4'd15, 1'b1);
        queue_render(8'hFF, 8'h88, 4'd15, 1'b1);
        queue_render(8'hFF, 8'h80, 4'd3,  1'b0);
        queue_render(8'h00, 8'h70, 4'd15, 1'b1);
        queue_render(8'hFF, 8'hF8, 4'd15, 1'b0);
        queue_render(8'hFF, 8'hF0, 4'd15, 1'b1);
        queue_render(8'h00, 8'h78, 4'd0,  1'b0);
        queue_render(8'h00, 8'h01, 4'd14, 1'b1);
        queue_render(8'hFF, 8'h09, 4'd14, 1'b1);
        queue_render(8'hFF, 8'h81, 4'd14, 1'b0);
        queue_render(8'hFF, 8'h81, 4'd14, 1'b1);
        queue_render(8'h00, 8'h01, 4'd13, 1'b1);
        queue_render(8'hFF, 8'h87, 4'd15, 1'b0);
        queue_render(8'hFF, 8'hFF, 4'd0,  1'b1);
        // load then render the same entry, then overwrite it and render it again
        queue_load({8'h42, 4'd3}, 8'h5A);
        queue_render(8'h42, 8'h07, 4'd3, 1'b1);
        queue_load({8'h42, 4'd3}, 8'hA5);
        queue_render(8'h42, 8'h0F, 4'd3, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: set_colors(24'h000000, 24'hFFFFFF);
                    2: set_colors(24'hFFFFFF, 24'h000000);
                    4: set_colors(24'hFFFFFF, 24'hFFFFFF);
                    default: set_colors(24'($urandom), 24'($urandom));
                endcase
            end
            no_idle = (phase == 2 || phase == 5);
            repeat (100) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    queue_load(12'($urandom), 8'($urandom));
                end else if (pick == 3) begin
                    a = 12'($urandom);
                    queue_load(a, 8'($urandom));
                    queue_render(a[11:4], pick_attr(), a[3:0], 1'($urandom_range(0, 1)));
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        a = {($urandom_range(0, 1) ? 8'hFF : 8'h00), UNDERLINE_ROW};
                    else
                        a = 12'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
                    queue_render(a[11:4], pick_attr(), a[3:0], 1'($urandom_range(0, 1)));
                end
            end
        end
        wait_idle();
        repeat (8) @(posedge aclk);

        $display("tb: %0d font loads and %0d cell rows over %0d color settings",
                 n_loads, n_renders, n_settings);
        $display("tb: %0d results checked, %0d mismatches", n_checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### mda_text_cell_row_render.f
src/mtcr_pkg.sv
src/mtcr_attr_decode.sv
src/mda_text_cell_row_render.sv
verif/tb.sv
